// File: design/rau_pkg.sv
package rau_pkg;

    localparam int OPERAND_WIDTH_DEF = 16;

    typedef enum logic [1:0] {
        REQ_ADD = 2'd0,
        REQ_SUB = 2'd1,
        REQ_MUL = 2'd2,
        REQ_RCP = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_COMB,
        ST_GCD,
        ST_GSHIFT,
        ST_DIV,
        ST_FIN
    } t_state;

endpackage

// File: design/rational_arithmetic_unit.sv
// Steps of a beat: shift-add products, combine, binary gcd steps, gcd shift back,
//   restoring divisions of both parts, then the final hand-off; W = OPERAND_WIDTH.
// Throughput: one beat at a time; the next beat is taken once the unit is idle,
//   even while the previous result still waits at the output register.
// Reciprocal beats go from acceptance straight to the final step; zero/zero beats skip gcd and division.
// Reset (i_rst_n low, synchronous) returns the sequencer to idle and drops o_out_valid.
module rational_arithmetic_unit #(
    parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [1:0]                   i_req_type,
    input  logic signed [OPERAND_WIDTH-1:0] i_a_num,
    input  logic signed [OPERAND_WIDTH-1:0] i_a_den,
    input  logic signed [OPERAND_WIDTH-1:0] i_b_num,
    input  logic signed [OPERAND_WIDTH-1:0] i_b_den,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic signed [2*OPERAND_WIDTH:0]   o_res_num,
    output logic signed [2*OPERAND_WIDTH-1:0] o_res_den,
    output logic                         o_gcd_zero
);
    import rau_pkg::*;

    localparam int W  = OPERAND_WIDTH;
    localparam int MW = 2 * W;
    localparam int NW = 2 * W + 1;
    localparam int CW = $clog2(MW + 1);

    t_state r_state, n_state;
    t_req   r_op, n_op;

    logic [MW-1:0] r_mc1, r_mc2, r_mc3, n_mc1, n_mc2, n_mc3;
    logic [W-1:0]  r_my1, r_my2, r_my3, n_my1, n_my2, n_my3;
    logic [MW-1:0] r_acc1, r_acc2, r_acc3, n_acc1, n_acc2, n_acc3;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_k, n_k;
    logic [NW-1:0] r_num, n_num;
    logic [MW-1:0] r_den, n_den;
    logic [MW-1:0] r_u, r_v, n_u, n_v;
    logic [MW-1:0] r_g, n_g;
    logic [MW-1:0] r_remn, r_remd, n_remn, n_remd;
    logic [MW-1:0] r_qn, r_qd, n_qn, n_qd;
    logic          r_skip, n_skip;
    logic          r_zero, n_zero;

    logic                r_ov, n_ov;
    logic [NW-1:0]       r_onum, n_onum;
    logic [MW-1:0]       r_oden, n_oden;
    logic                r_oz, n_oz;

    logic [NW-1:0] w_n;
    logic [NW-1:0] w_nabs;
    logic [MW-1:0] w_dabs;
    logic [MW:0]   w_shn, w_shd;
    logic [NW-1:0] w_numabs;
    logic [MW-1:0] w_denabs;
    logic          w_out_free;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_ov;
    assign o_res_num   = r_onum;
    assign o_res_den   = r_oden;
    assign o_gcd_zero  = r_oz;

    // hold state and payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
        r_op <= n_op;
        r_mc1 <= n_mc1; r_mc2 <= n_mc2; r_mc3 <= n_mc3;
        r_my1 <= n_my1; r_my2 <= n_my2; r_my3 <= n_my3;
        r_acc1 <= n_acc1; r_acc2 <= n_acc2; r_acc3 <= n_acc3;
        r_cnt <= n_cnt; r_k <= n_k;
        r_num <= n_num; r_den <= n_den;
        r_u <= n_u; r_v <= n_v; r_g <= n_g;
        r_remn <= n_remn; r_remd <= n_remd;
        r_qn <= n_qn; r_qd <= n_qd;
        r_skip <= n_skip; r_zero <= n_zero;
        r_onum <= n_onum; r_oden <= n_oden; r_oz <= n_oz;
    end

    // combine products and take magnitudes
    always_comb begin
        if (r_op == REQ_SUB) begin
            w_n = {r_acc1[MW-1], r_acc1} - {r_acc2[MW-1], r_acc2};
        end else begin
            w_n = {r_acc1[MW-1], r_acc1} + {r_acc2[MW-1], r_acc2};
        end
        w_nabs   = w_n[NW-1] ? (~w_n + 1'b1) : w_n;
        w_dabs   = r_acc3[MW-1] ? (~r_acc3 + 1'b1) : r_acc3;
        w_numabs = r_num[NW-1] ? (~r_num + 1'b1) : r_num;
        w_denabs = r_den[MW-1] ? (~r_den + 1'b1) : r_den;
        w_shn    = {r_remn, r_qn[MW-1]};
        w_shd    = {r_remd, r_qd[MW-1]};
        w_out_free = !r_ov || i_out_ready;
    end

    // sequence one beat through multiply, gcd and divide
    always_comb begin
        n_state = r_state;
        n_op = r_op;
        n_mc1 = r_mc1; n_mc2 = r_mc2; n_mc3 = r_mc3;
        n_my1 = r_my1; n_my2 = r_my2; n_my3 = r_my3;
        n_acc1 = r_acc1; n_acc2 = r_acc2; n_acc3 = r_acc3;
        n_cnt = r_cnt; n_k = r_k;
        n_num = r_num; n_den = r_den;
        n_u = r_u; n_v = r_v; n_g = r_g;
        n_remn = r_remn; n_remd = r_remd;
        n_qn = r_qn; n_qd = r_qd;
        n_skip = r_skip; n_zero = r_zero;
        n_ov = r_ov; n_onum = r_onum; n_oden = r_oden; n_oz = r_oz;

        if (r_ov && i_out_ready) begin
            n_ov = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_op   = t_req'(i_req_type);
                    n_acc1 = '0; n_acc2 = '0; n_acc3 = '0;
                    n_cnt  = '0;
                    n_zero = 1'b0;
                    n_skip = 1'b0;
                    n_mc1  = {{(MW-W){i_a_num[W-1]}}, i_a_num};
                    n_mc3  = {{(MW-W){i_a_den[W-1]}}, i_a_den};
                    n_my3  = i_b_den;
                    if (t_req'(i_req_type) == REQ_MUL) begin
                        n_my1 = i_b_num;
                        n_mc2 = '0;
                        n_my2 = '0;
                    end else begin
                        n_my1 = i_b_den;
                        n_mc2 = {{(MW-W){i_b_num[W-1]}}, i_b_num};
                        n_my2 = i_a_den;
                    end
                    if (t_req'(i_req_type) == REQ_RCP) begin
                        n_num   = {{(NW-W){i_a_den[W-1]}}, i_a_den};
                        n_den   = {{(MW-W){i_a_num[W-1]}}, i_a_num};
                        n_skip  = 1'b1;
                        n_state = ST_FIN;
                    end else begin
                        n_state = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                // add one partial product a cycle; top bit carries negative weight
                if (r_cnt == CW'(W - 1)) begin
                    n_acc1 = r_acc1 - (r_my1[0] ? r_mc1 : '0);
                    n_acc2 = r_acc2 - (r_my2[0] ? r_mc2 : '0);
                    n_acc3 = r_acc3 - (r_my3[0] ? r_mc3 : '0);
                    n_state = ST_COMB;
                end else begin
                    n_acc1 = r_acc1 + (r_my1[0] ? r_mc1 : '0);
                    n_acc2 = r_acc2 + (r_my2[0] ? r_mc2 : '0);
                    n_acc3 = r_acc3 + (r_my3[0] ? r_mc3 : '0);
                end
                n_mc1 = r_mc1 << 1; n_mc2 = r_mc2 << 1; n_mc3 = r_mc3 << 1;
                n_my1 = r_my1 >> 1; n_my2 = r_my2 >> 1; n_my3 = r_my3 >> 1;
                n_cnt = r_cnt + 1'b1;
            end
            ST_COMB: begin
                n_num = w_n;
                n_den = r_acc3;
                n_u   = w_nabs[MW-1:0];
                n_v   = w_dabs;
                n_k   = '0;
                if (w_nabs == '0 && w_dabs == '0) begin
                    n_zero  = 1'b1;
                    n_skip  = 1'b1;
                    n_state = ST_FIN;
                end else begin
                    n_state = ST_GCD;
                end
            end
            ST_GCD: begin
                // binary gcd, one step a cycle
                if (r_u == '0) begin
                    n_g = r_v;
                    n_state = ST_GSHIFT;
                end else if (r_v == '0) begin
                    n_g = r_u;
                    n_state = ST_GSHIFT;
                end else if (!r_u[0] && !r_v[0]) begin
                    n_u = r_u >> 1;
                    n_v = r_v >> 1;
                    n_k = r_k + 1'b1;
                end else if (!r_u[0]) begin
                    n_u = r_u >> 1;
                end else if (!r_v[0]) begin
                    n_v = r_v >> 1;
                end else if (r_u >= r_v) begin
                    n_u = r_u - r_v;
                end else begin
                    n_v = r_v - r_u;
                end
            end
            ST_GSHIFT: begin
                // restore common factors of two, then load the dividers
                if (r_k == '0) begin
                    n_remn  = '0;
                    n_remd  = '0;
                    n_qn    = w_numabs[MW-1:0];
                    n_qd    = w_denabs;
                    n_cnt   = '0;
                    n_state = ST_DIV;
                end else begin
                    n_g = r_g << 1;
                    n_k = r_k - 1'b1;
                end
            end
            ST_DIV: begin
                // restoring division, one quotient bit a cycle
                if (w_shn >= {1'b0, r_g}) begin
                    n_remn = MW'(w_shn - {1'b0, r_g});
                    n_qn   = {r_qn[MW-2:0], 1'b1};
                end else begin
                    n_remn = w_shn[MW-1:0];
                    n_qn   = {r_qn[MW-2:0], 1'b0};
                end
                if (w_shd >= {1'b0, r_g}) begin
                    n_remd = MW'(w_shd - {1'b0, r_g});
                    n_qd   = {r_qd[MW-2:0], 1'b1};
                end else begin
                    n_remd = w_shd[MW-1:0];
                    n_qd   = {r_qd[MW-2:0], 1'b0};
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CW'(MW - 1)) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                // hand the result to the output register once it is free
                if (w_out_free) begin
                    n_ov = 1'b1;
                    n_oz = r_zero;
                    if (r_skip) begin
                        n_onum = r_num;
                        n_oden = r_den;
                    end else begin
                        n_onum = r_num[NW-1] ? (~{1'b0, r_qn} + 1'b1) : {1'b0, r_qn};
                        n_oden = r_den[MW-1] ? (~r_qd + 1'b1) : r_qd;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // zero flag only ever comes with an unreduced zero over zero
    a_zero_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_gcd_zero) |-> (o_res_num == '0 && o_res_den == '0))
        else $error("gcd_zero with nonzero result");

    // the gcd loop never runs on two zeros
    a_gcd_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_GCD) |-> (r_u != '0 || r_v != '0))
        else $error("gcd entered with both values zero");

    // dividers never see a zero divisor
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_g != '0))
        else $error("division by zero gcd");

    // an accepted beat starts work
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == ST_MUL || r_state == ST_FIN))
        else $error("accepted beat did not start");

endmodule
